// ----- src/lcdns_pkg.sv -----
// Package for the character LCD nibble sequencer.
// Holds shared widths, timing constants, command/status structs and the fixed tables.
// No dependencies.
package lcdns_pkg;

    // display geometry
    localparam int LINE_CHARS   = 16;
    localparam int CUR_W        = $clog2(2 * LINE_CHARS + 1);
    localparam int CUR_LAST     = 2 * LINE_CHARS - 1;
    localparam int LINE2_BASE   = 8'h40;

    // field widths
    localparam int PAUSE_W      = 12;
    localparam int AFTER_W      = 5;

    // idle times in milliseconds
    localparam int STD_MS       = 2;
    localparam int CURSOR_MS    = 3;
    localparam int NIB_MS       = 3;
    localparam int CHAR_MS      = 30;
    localparam int ERR_HOLD_MS  = 4000;

    // fixed sequences
    localparam int INIT_LEN     = 12;
    localparam int STEP_W       = $clog2(INIT_LEN);
    localparam int ERR_TEXT_LEN = 21;
    localparam int TXT_W        = $clog2(ERR_TEXT_LEN);

    typedef enum logic [1:0] {
        KIND_INIT  = 2'd0,
        KIND_CLEAR = 2'd1,
        KIND_SET   = 2'd2,
        KIND_CHAR  = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        NIB_CONST,
        NIB_CHAR_HI,
        NIB_CHAR_LO,
        NIB_SET_HI,
        NIB_SET_LO
    } nib_sel_t;

    typedef enum logic [1:0] {
        CUR_HOLD,
        CUR_ZERO,
        CUR_INC,
        CUR_PLACE
    } cur_op_t;

    // controller to datapath
    typedef struct packed {
        logic               accept;
        logic               emit;
        logic               rs;
        nib_sel_t           nib_sel;
        logic [3:0]         nib_const;
        logic               use_text;
        logic [TXT_W-1:0]   text_idx;
        logic [PAUSE_W-1:0] pre;
        logic [AFTER_W-1:0] post;
        logic               last;
        logic               err;
        cur_op_t            cur_op;
        logic               load_wrap;
        logic               set_discard;
    } lcdns_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;
        logic wrap_hit;
        logic over_hit;
        logic discard;
    } lcdns_stat_t;

    function automatic logic [PAUSE_W-1:0] init_pause(input logic [STEP_W-1:0] idx);
        logic [PAUSE_W-1:0] val;
        case (idx)
            4'd0:    val = PAUSE_W'(16);
            4'd1:    val = PAUSE_W'(5);
            4'd3:    val = PAUSE_W'(5);
            default: val = PAUSE_W'(2);
        endcase
        return val;
    endfunction

    function automatic logic [3:0] init_nib(input logic [STEP_W-1:0] idx);
        logic [3:0] val;
        case (idx)
            4'd0:    val = 4'h3;
            4'd1:    val = 4'h3;
            4'd2:    val = 4'h3;
            4'd3:    val = 4'h2;
            4'd4:    val = 4'h2;
            4'd5:    val = 4'hF;
            4'd6:    val = 4'h0;
            4'd7:    val = 4'h1;
            4'd8:    val = 4'h0;
            4'd9:    val = 4'h6;
            4'd10:   val = 4'h0;
            4'd11:   val = 4'hF;
            default: val = 4'h0;
        endcase
        return val;
    endfunction

    // overflow message text
    function automatic logic [7:0] err_char(input logic [TXT_W-1:0] idx);
        logic [7:0] val;
        case (idx)
            5'd0:    val = "E";
            5'd1:    val = "r";
            5'd2:    val = "r";
            5'd3:    val = "o";
            5'd4:    val = "r";
            5'd5:    val = ":";
            5'd6:    val = " ";
            5'd7:    val = "i";
            5'd8:    val = "n";
            5'd9:    val = "p";
            5'd10:   val = "u";
            5'd11:   val = "t";
            5'd12:   val = " ";
            5'd13:   val = "t";
            5'd14:   val = "o";
            5'd15:   val = "o";
            5'd16:   val = " ";
            5'd17:   val = "l";
            5'd18:   val = "o";
            5'd19:   val = "n";
            5'd20:   val = "g";
            default: val = " ";
        endcase
        return val;
    endfunction

endpackage

// ----- src/lcdns_cmd_if.sv -----
// Command channel interface of the LCD nibble sequencer.
// Depends on lcdns_pkg.
interface lcdns_cmd_if import lcdns_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] char_code;
    logic [4:0] cursor_place;
    logic       end_of_string;

    modport source (output valid, kind, char_code, cursor_place, end_of_string, input ready);
    modport sink   (input valid, kind, char_code, cursor_place, end_of_string, output ready);
endinterface

// ----- src/lcdns_strobe_if.sv -----
// Strobe channel interface of the LCD nibble sequencer.
// Depends on lcdns_pkg.
interface lcdns_strobe_if import lcdns_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               reg_select;
    logic [3:0]         nibble;
    logic [PAUSE_W-1:0] pause_before_ms;
    logic [AFTER_W-1:0] pause_after_ms;
    logic               overflow_run;
    logic               last;

    modport source (output valid, reg_select, nibble, pause_before_ms, pause_after_ms,
                    overflow_run, last, input ready);
    modport sink   (input valid, reg_select, nibble, pause_before_ms, pause_after_ms,
                    overflow_run, last, output ready);
endinterface

// ----- src/lcdns_ctrl.sv -----
// Controller of the LCD nibble sequencer: walks the strobe sequence of each request.
// Depends on lcdns_pkg.
module lcdns_ctrl import lcdns_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic [1:0]  kind,
    output logic        in_ready,
    input  lcdns_stat_t stat,
    output lcdns_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_CLR0,
        S_CLR1,
        S_SET0,
        S_SET1,
        S_CHR_HI,
        S_CHR_LO
    } state_t;

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [TXT_W-1:0]  text_idx_reg, text_idx_next;
    logic              err_reg, err_next;
    logic              final_reg, final_next;
    logic              go;

    assign in_ready = (state_reg == S_IDLE);
    assign go       = stat.out_free;

    always_comb
    begin
        state_next    = state_reg;
        step_next     = step_reg;
        text_idx_next = text_idx_reg;
        err_next      = err_reg;
        final_next    = final_reg;

        cmd             = '0;
        cmd.nib_sel     = NIB_CONST;
        cmd.cur_op      = CUR_HOLD;
        cmd.accept      = in_valid && (state_reg == S_IDLE);
        cmd.err         = err_reg;
        cmd.use_text    = err_reg;
        cmd.text_idx    = text_idx_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd.accept)
                begin
                    err_next      = 1'b0;
                    final_next    = 1'b0;
                    text_idx_next = '0;
                    step_next     = '0;
                    case (kind_t'(kind))
                        KIND_INIT:  state_next = S_INIT;
                        KIND_CLEAR: state_next = S_CLR0;
                        KIND_SET:   state_next = S_SET0;
                        KIND_CHAR:  state_next = stat.discard ? S_IDLE : S_CHR_HI;
                        default:    state_next = S_IDLE;
                    endcase
                end
            end

            S_INIT:
            begin
                cmd.emit      = go;
                cmd.nib_const = init_nib(step_reg);
                cmd.pre       = init_pause(step_reg);
                if (step_reg == STEP_W'(INIT_LEN - 1))
                begin
                    cmd.last   = 1'b1;
                    cmd.post   = AFTER_W'(STD_MS);
                    cmd.cur_op = CUR_ZERO;
                end
                if (go)
                begin
                    if (step_reg == STEP_W'(INIT_LEN - 1))
                        state_next = S_IDLE;
                    else
                        step_next = step_reg + 1'b1;
                end
            end

            S_CLR0:
            begin
                cmd.emit      = go;
                cmd.nib_const = 4'h0;
                cmd.pre       = final_reg ? PAUSE_W'(ERR_HOLD_MS + STD_MS) : PAUSE_W'(STD_MS);
                cmd.post      = AFTER_W'(STD_MS);
                if (go)
                    state_next = S_CLR1;
            end

            S_CLR1:
            begin
                cmd.emit        = go;
                cmd.nib_const   = 4'h1;
                cmd.post        = AFTER_W'(STD_MS);
                cmd.last        = !err_reg || final_reg;
                cmd.cur_op      = CUR_ZERO;
                cmd.set_discard = err_reg && final_reg;
                if (go)
                    state_next = (err_reg && !final_reg) ? S_CHR_HI : S_IDLE;
            end

            S_SET0:
            begin
                cmd.emit    = go;
                cmd.nib_sel = NIB_SET_HI;
                cmd.pre     = PAUSE_W'(CURSOR_MS);
                cmd.post    = AFTER_W'(STD_MS);
                if (go)
                    state_next = S_SET1;
            end

            S_SET1:
            begin
                cmd.emit    = go;
                cmd.nib_sel = NIB_SET_LO;
                cmd.post    = AFTER_W'(STD_MS + CURSOR_MS);
                cmd.last    = !err_reg;
                cmd.cur_op  = CUR_PLACE;
                if (go)
                begin
                    if (!err_reg)
                        state_next = S_IDLE;
                    else if (text_idx_reg == TXT_W'(ERR_TEXT_LEN - 1))
                    begin
                        final_next = 1'b1;
                        state_next = S_CLR0;
                    end
                    else
                    begin
                        text_idx_next = text_idx_reg + 1'b1;
                        state_next    = S_CHR_HI;
                    end
                end
            end

            S_CHR_HI:
            begin
                cmd.emit    = go;
                cmd.rs      = 1'b1;
                cmd.nib_sel = NIB_CHAR_HI;
                cmd.post    = AFTER_W'(NIB_MS);
                if (go)
                    state_next = S_CHR_LO;
            end

            S_CHR_LO:
            begin
                cmd.emit      = go;
                cmd.rs        = 1'b1;
                cmd.nib_sel   = NIB_CHAR_LO;
                cmd.post      = AFTER_W'(CHAR_MS);
                cmd.cur_op    = CUR_INC;
                cmd.load_wrap = stat.wrap_hit;
                cmd.last      = !err_reg && !stat.wrap_hit && !stat.over_hit;
                if (go)
                begin
                    if (stat.wrap_hit)
                        state_next = S_SET0;
                    else if (err_reg)
                    begin
                        // advance through the message, then the closing clear
                        if (text_idx_reg == TXT_W'(ERR_TEXT_LEN - 1))
                        begin
                            final_next = 1'b1;
                            state_next = S_CLR0;
                        end
                        else
                        begin
                            text_idx_next = text_idx_reg + 1'b1;
                            state_next    = S_CHR_HI;
                        end
                    end
                    else if (stat.over_hit)
                    begin
                        err_next      = 1'b1;
                        final_next    = 1'b0;
                        text_idx_next = '0;
                        state_next    = S_CLR0;
                    end
                    else
                        state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            step_reg     <= '0;
            text_idx_reg <= '0;
            err_reg      <= 1'b0;
            final_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            step_reg     <= step_next;
            text_idx_reg <= text_idx_next;
            err_reg      <= err_next;
            final_reg    <= final_next;
        end
    end

endmodule

// ----- src/lcdns_dp.sv -----
// Datapath of the LCD nibble sequencer: cursor, pause accumulator and output register.
// Depends on lcdns_pkg.
module lcdns_dp import lcdns_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  lcdns_cmd_t         cmd,
    output lcdns_stat_t        stat,
    input  logic [1:0]         kind,
    input  logic [7:0]         char_code,
    input  logic [4:0]         cursor_place,
    input  logic               end_of_string,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               reg_select,
    output logic [3:0]         nibble,
    output logic [PAUSE_W-1:0] pause_before_ms,
    output logic [AFTER_W-1:0] pause_after_ms,
    output logic               overflow_run,
    output logic               last
);

    logic [CUR_W-1:0]   cursor_reg, cursor_next;
    logic               discard_reg, discard_next;
    logic               out_valid_reg;
    logic [PAUSE_W-1:0] pend_reg;
    logic               eos_reg;
    logic [7:0]         char_reg;
    logic [CUR_W-1:0]   place_reg;
    logic               rs_reg;
    logic [3:0]         nib_reg;
    logic [PAUSE_W-1:0] before_reg;
    logic [AFTER_W-1:0] after_reg;
    logic               err_reg;
    logic               last_reg;

    logic [CUR_W-1:0]   cursor_inc;
    logic [CUR_W-1:0]   place_sat;
    logic [7:0]         place8;
    logic [7:0]         addr8;
    logic [7:0]         chr;
    logic [3:0]         nib;

    assign cursor_inc    = cursor_reg + 1'b1;
    assign stat.out_free = !out_valid_reg || out_ready;
    assign stat.wrap_hit = (cursor_inc == CUR_W'(LINE_CHARS));
    assign stat.over_hit = (cursor_inc >= CUR_W'(2 * LINE_CHARS));
    assign stat.discard  = discard_reg;

    // clamp a place beyond the display to its last position
    assign place_sat = ({3'b000, cursor_place} > 8'(CUR_LAST)) ? CUR_W'(CUR_LAST)
                                                              : CUR_W'(cursor_place);

    // display address: line two starts at LINE2_BASE
    assign place8 = 8'(place_reg);
    assign addr8  = (place8 < 8'(LINE_CHARS)) ? place8
                                              : 8'(LINE2_BASE) + place8 - 8'(LINE_CHARS);
    assign chr    = cmd.use_text ? err_char(cmd.text_idx) : char_reg;

    always_comb
    begin
        case (cmd.nib_sel)
            NIB_CONST:   nib = cmd.nib_const;
            NIB_CHAR_HI: nib = chr[7:4];
            NIB_CHAR_LO: nib = chr[3:0];
            NIB_SET_HI:  nib = {1'b1, addr8[6:4]};
            NIB_SET_LO:  nib = addr8[3:0];
            default:     nib = 4'h0;
        endcase
    end

    always_comb
    begin
        cursor_next = cursor_reg;
        if (cmd.emit)
        begin
            case (cmd.cur_op)
                CUR_HOLD:  cursor_next = cursor_reg;
                CUR_ZERO:  cursor_next = '0;
                CUR_INC:   cursor_next = cursor_inc;
                CUR_PLACE: cursor_next = place_reg;
                default:   cursor_next = cursor_reg;
            endcase
        end
    end

    always_comb
    begin
        discard_next = discard_reg;
        if (cmd.accept)
        begin
            if (kind_t'(kind) != KIND_CHAR)
                discard_next = 1'b0;
            else if (discard_reg && end_of_string)
                discard_next = 1'b0;
        end
        else if (cmd.emit && cmd.set_discard && !eos_reg)
            discard_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg    <= '0;
            discard_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            pend_reg      <= '0;
        end
        else
        begin
            cursor_reg  <= cursor_next;
            discard_reg <= discard_next;
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (cmd.accept)
                pend_reg <= '0;
            else if (cmd.emit)
                pend_reg <= PAUSE_W'(cmd.post);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            char_reg  <= char_code;
            eos_reg   <= end_of_string;
            place_reg <= place_sat;
        end
        else if (cmd.emit && cmd.load_wrap)
            place_reg <= CUR_W'(LINE_CHARS);

        if (cmd.emit)
        begin
            rs_reg     <= cmd.rs;
            nib_reg    <= nib;
            before_reg <= pend_reg + cmd.pre;
            after_reg  <= cmd.last ? cmd.post : '0;
            err_reg    <= cmd.err;
            last_reg   <= cmd.last;
        end
    end

    assign out_valid       = out_valid_reg;
    assign reg_select      = rs_reg;
    assign nibble          = nib_reg;
    assign pause_before_ms = before_reg;
    assign pause_after_ms  = after_reg;
    assign overflow_run    = err_reg;
    assign last            = last_reg;

endmodule

// ----- src/char_lcd_nibble_sequencer.sv -----
// Top level of the character LCD nibble sequencer.
// Depends on lcdns_pkg, lcdns_cmd_if, lcdns_strobe_if, lcdns_ctrl and lcdns_dp.
//
// Usage:
//   cmd    takes one request: init, clear, set cursor or write char.
//   strobe gives the enable strobes of that request in order, one per item, each
//          with RS, nibble DB7..DB4, idle time before enable and, on the strobe
//          flagged last, idle time after it.
//   The controller issues at most one strobe per cycle into a single output register.
//   A new request is taken only once the controller has issued the last strobe of
//   the previous one. After a request is taken, the controller state register moves
//   to its first step, which emits the first strobe into the output register. A write
//   char dropped after an overflow gives no strobe and leaves the controller idle.
//   cmd.ready is high whenever the controller is between requests, even while the
//   last strobe of the previous request still waits in the output register.
//   Reset clears the cursor to position 0, ends any drop of a string and empties
//   the output register. When the receiver stalls, the pending strobe holds and
//   the controller waits on the same step; no strobe is lost.
module char_lcd_nibble_sequencer import lcdns_pkg::*; (
    input  logic           clk,
    input  logic           rst_n,
    lcdns_cmd_if.sink      cmd,
    lcdns_strobe_if.source strobe
);

    lcdns_cmd_t  ctrl_cmd;
    lcdns_stat_t dp_stat;

    // sequence control: one step per strobe
    lcdns_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cmd.valid),
        .kind     (cmd.kind),
        .in_ready (cmd.ready),
        .stat     (dp_stat),
        .cmd      (ctrl_cmd)
    );

    // cursor tracking, pause accumulation and the strobe output register
    lcdns_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (ctrl_cmd),
        .stat            (dp_stat),
        .kind            (cmd.kind),
        .char_code       (cmd.char_code),
        .cursor_place    (cmd.cursor_place),
        .end_of_string   (cmd.end_of_string),
        .out_valid       (strobe.valid),
        .out_ready       (strobe.ready),
        .reg_select      (strobe.reg_select),
        .nibble          (strobe.nibble),
        .pause_before_ms (strobe.pause_before_ms),
        .pause_after_ms  (strobe.pause_after_ms),
        .overflow_run    (strobe.overflow_run),
        .last            (strobe.last)
    );

endmodule

// ----- src/lcdns_checker.sv -----
// Port-level checker for the LCD nibble sequencer, bound to the top level.
// Depends on lcdns_pkg and char_lcd_nibble_sequencer.
module lcdns_checker import lcdns_pkg::*; (
    input logic               clk,
    input logic               rst_n,
    input logic               cmd_valid,
    input logic               cmd_ready,
    input logic [1:0]         cmd_kind,
    input logic               strobe_valid,
    input logic               strobe_ready,
    input logic               strobe_reg_select,
    input logic [3:0]         strobe_nibble,
    input logic [PAUSE_W-1:0] strobe_pause_before_ms,
    input logic [AFTER_W-1:0] strobe_pause_after_ms,
    input logic               strobe_overflow_run,
    input logic               strobe_last
);

    // a stalled strobe holds its payload
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_valid && !strobe_ready |=> strobe_valid
            && $stable(strobe_nibble) && $stable(strobe_pause_before_ms)
            && $stable(strobe_last))
        else $error("stalled strobe changed");

    // only the final strobe of a request carries idle time after it
    a_after_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_valid |-> (strobe_last == (strobe_pause_after_ms != '0)))
        else $error("pause_after_ms does not match last");

    // an overflow run ends with the second nibble of a clear
    a_overflow_end: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_valid && strobe_last && strobe_overflow_run
            |-> !strobe_reg_select && (strobe_nibble == 4'h1))
        else $error("overflow run ends with wrong strobe");

    // any request other than write char always produces strobes, so the port closes
    a_busy_after_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready && (cmd_kind != KIND_CHAR) |=> !cmd_ready)
        else $error("command port open during a sequence");

endmodule

bind char_lcd_nibble_sequencer lcdns_checker u_lcdns_checker (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cmd_valid              (cmd.valid),
    .cmd_ready              (cmd.ready),
    .cmd_kind               (cmd.kind),
    .strobe_valid           (strobe.valid),
    .strobe_ready           (strobe.ready),
    .strobe_reg_select      (strobe.reg_select),
    .strobe_nibble          (strobe.nibble),
    .strobe_pause_before_ms (strobe.pause_before_ms),
    .strobe_pause_after_ms  (strobe.pause_after_ms),
    .strobe_overflow_run    (strobe.overflow_run),
    .strobe_last            (strobe.last)
);

// ----- bench/char_lcd_nibble_sequencer_tb.sv -----
// Self-checking testbench for char_lcd_nibble_sequencer: directed and random display
// requests, with an in-bench prediction of every enable strobe they should produce.
// Depends on lcdns_pkg, lcdns_cmd_if, lcdns_strobe_if and the sequencer RTL.
module char_lcd_nibble_sequencer_tb;
    import lcdns_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Display geometry and idle times, kept local so the prediction stands on its own.
    localparam int          ROW_LEN      = 16;
    localparam logic [7:0]  SET_DDRAM    = 8'h80;
    localparam int          ROW2_ADDR    = 8'h40;
    localparam int unsigned CMD_GAP_MS   = 2;
    localparam int unsigned ADDR_GAP_MS  = 3;
    localparam int unsigned NIB_GAP_MS   = 3;
    localparam int unsigned CHAR_GAP_MS  = 30;
    localparam int unsigned ERR_SHOW_MS  = 4000;
    localparam int          POWER_UP_LEN = 12;
    localparam int          PHASE_GOAL   = 42;

    // Power-up nibble sequence and the idle time ahead of each of its strobes.
    localparam logic [3:0] POWER_UP_NIBS [POWER_UP_LEN] =
        '{4'h3, 4'h3, 4'h3, 4'h2, 4'h2, 4'hF, 4'h0, 4'h1, 4'h0, 4'h6, 4'h0, 4'hF};
    localparam int unsigned POWER_UP_GAPS [POWER_UP_LEN] =
        '{16, 5, 2, 5, 2, 2, 2, 2, 2, 2, 2, 2};

    typedef struct {
        kind_t      kind;
        logic [7:0] code;
        logic [4:0] place;
        logic       eos;
    } lcd_req_t;

    typedef struct packed {
        logic               rs;
        logic [3:0]         nib;
        logic [PAUSE_W-1:0] pre;
        logic [AFTER_W-1:0] post;
        logic               ovf;
        logic               last;
    } lcd_strobe_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    lcdns_cmd_if    cmd_ch ();
    lcdns_strobe_if strobe_ch ();

    char_lcd_nibble_sequencer dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd_ch),
        .strobe (strobe_ch)
    );

    always #1 clk = ~clk;

    // Requests waiting for the driver, and strobes predicted but not yet seen.
    lcd_req_t    cmd_backlog[$];
    lcd_req_t    on_bus;
    lcd_strobe_t pending_strobes[$];
    lcd_strobe_t cmd_strobes[$];

    // Display state tracked by the predictor.
    int unsigned lcd_cursor;
    bit          drop_string;
    int unsigned gap_ms;
    bit          err_run;
    string       err_banner = "Error: input too long";

    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned queued_cnt;
    int unsigned accepted_cnt;
    int unsigned productive_cnt;
    int unsigned strobe_cnt;
    int unsigned overflow_cnt;
    int unsigned fail_cnt;

    // Emit one predicted strobe; the idle time gathered so far goes in front of it.
    function automatic void push_strobe(bit rs, logic [3:0] nib);
        lcd_strobe_t s;
        s.rs   = rs;
        s.nib  = nib;
        s.pre  = PAUSE_W'(gap_ms);
        s.post = '0;
        s.ovf  = err_run;
        s.last = 1'b0;
        gap_ms = 0;
        cmd_strobes.push_back(s);
    endfunction

    function automatic void seq_clear();
        gap_ms += CMD_GAP_MS;
        push_strobe(1'b0, 4'h0);
        gap_ms += CMD_GAP_MS;
        push_strobe(1'b0, 4'h1);
        gap_ms += CMD_GAP_MS;
        lcd_cursor = 0;
    endfunction

    function automatic void seq_goto(int unsigned place);
        int unsigned pos;
        logic [7:0]  addr;
        pos = place;
        // saturate a place past the display to its last cell
        if (pos > 2 * ROW_LEN - 1)
            pos = 2 * ROW_LEN - 1;
        addr = (pos < ROW_LEN) ? 8'(pos) : 8'(ROW2_ADDR + pos - ROW_LEN);
        addr &= 8'h7F;
        gap_ms += ADDR_GAP_MS;
        push_strobe(1'b0, 4'((SET_DDRAM | addr) >> 4));
        gap_ms += CMD_GAP_MS;
        push_strobe(1'b0, addr[3:0]);
        gap_ms += CMD_GAP_MS + ADDR_GAP_MS;
        lcd_cursor = pos;
    endfunction

    // Write one byte as two data nibbles; wrap to line two at the end of line one.
    function automatic void seq_char(logic [7:0] c);
        push_strobe(1'b1, c[7:4]);
        gap_ms += NIB_GAP_MS;
        push_strobe(1'b1, c[3:0]);
        gap_ms += CHAR_GAP_MS;
        lcd_cursor++;
        if (lcd_cursor == ROW_LEN)
            seq_goto(ROW_LEN);
    endfunction

    // Work out every strobe one accepted request causes and queue them for checking.
    function automatic int predict_strobes(lcd_req_t r);
        cmd_strobes.delete();
        gap_ms  = 0;
        err_run = 1'b0;
        if (r.kind == KIND_CHAR) begin
            if (drop_string) begin
                // swallow the rest of an overflowed string up to its end marker
                if (r.eos)
                    drop_string = 1'b0;
                return 0;
            end
            seq_char(r.code);
            if (lcd_cursor >= 2 * ROW_LEN) begin
                // overflow: clear, show the error text, hold it, clear again
                err_run = 1'b1;
                seq_clear();
                for (int i = 0; i < err_banner.len(); i++)
                    seq_char(err_banner[i]);
                gap_ms += ERR_SHOW_MS;
                seq_clear();
                if (!r.eos)
                    drop_string = 1'b1;
                overflow_cnt++;
            end
        end else begin
            drop_string = 1'b0;
            case (r.kind)
                KIND_INIT: begin
                    for (int i = 0; i < POWER_UP_LEN; i++) begin
                        gap_ms += POWER_UP_GAPS[i];
                        push_strobe(1'b0, POWER_UP_NIBS[i]);
                    end
                    gap_ms += CMD_GAP_MS;
                    lcd_cursor = 0;
                end
                KIND_CLEAR: seq_clear();
                default:    seq_goto(r.place);
            endcase
        end
        // trailing idle time rides on the final strobe of the request
        if (cmd_strobes.size() > 0) begin
            cmd_strobes[cmd_strobes.size() - 1].post = AFTER_W'(gap_ms);
            cmd_strobes[cmd_strobes.size() - 1].last = 1'b1;
        end
        foreach (cmd_strobes[i])
            pending_strobes.push_back(cmd_strobes[i]);
        return cmd_strobes.size();
    endfunction

    function automatic void push_req(kind_t kind, logic [7:0] code, logic [4:0] place,
                                     logic eos);
        lcd_req_t r;
        r.kind  = kind;
        r.code  = code;
        r.place = place;
        r.eos   = eos;
        cmd_backlog.push_back(r);
        queued_cnt++;
    endfunction

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            $display("%0t ns: strobe %s mismatch, expected %0h, actual %0h",
                     $time, name, want, got);
            fail_cnt++;
        end
    endfunction

    // Driver: present the next request from the backlog, predict on acceptance.
    always @(posedge clk or negedge rst_n) begin
        lcd_req_t nxt;
        int       n;
        if (!rst_n) begin
            cmd_ch.valid <= 1'b0;
        end else begin
            if (cmd_ch.valid && cmd_ch.ready) begin
                accepted_cnt++;
                n = predict_strobes(on_bus);
                if (n > 0)
                    productive_cnt++;
            end
            // advance only when the bus is free or the current request was taken
            if (!cmd_ch.valid || cmd_ch.ready) begin
                if (cmd_backlog.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    nxt = cmd_backlog.pop_front();
                    on_bus <= nxt;
                    cmd_ch.kind          <= nxt.kind;
                    cmd_ch.char_code     <= nxt.code;
                    cmd_ch.cursor_place  <= nxt.place;
                    cmd_ch.end_of_string <= nxt.eos;
                    cmd_ch.valid         <= 1'b1;
                end else begin
                    cmd_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: stall at random, check each accepted strobe against the oldest prediction.
    always @(posedge clk or negedge rst_n) begin
        lcd_strobe_t want;
        if (!rst_n) begin
            strobe_ch.ready <= 1'b0;
        end else begin
            if (strobe_ch.valid && strobe_ch.ready) begin
                strobe_cnt++;
                if (pending_strobes.size() == 0) begin
                    $display("%0t ns: strobe mismatch, expected none, actual rs=%0d nibble=%0h",
                             $time, strobe_ch.reg_select, strobe_ch.nibble);
                    fail_cnt++;
                end else begin
                    want = pending_strobes.pop_front();
                    check_field("reg_select", 16'(want.rs), 16'(strobe_ch.reg_select));
                    check_field("nibble", 16'(want.nib), 16'(strobe_ch.nibble));
                    check_field("pause_before_ms", 16'(want.pre),
                                16'(strobe_ch.pause_before_ms));
                    check_field("pause_after_ms", 16'(want.post),
                                16'(strobe_ch.pause_after_ms));
                    check_field("overflow_run", 16'(want.ovf), 16'(strobe_ch.overflow_run));
                    check_field("last", 16'(want.last), 16'(strobe_ch.last));
                end
            end
            strobe_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Watchdog: far beyond the slowest legal run of all phases.
    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    initial begin
        int unsigned pick;
        int unsigned len;
        int unsigned goal;

        // hold every input at a known level from time zero
        cmd_ch.valid         = 1'b0;
        cmd_ch.kind          = KIND_INIT;
        cmd_ch.char_code     = 8'h00;
        cmd_ch.cursor_place  = 5'd0;
        cmd_ch.end_of_string = 1'b0;
        strobe_ch.ready      = 1'b0;
        lcd_cursor     = 0;
        drop_string    = 1'b0;
        send_idle_pct  = 14;
        recv_stall_pct = 52;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part: every kind, field extremes, line wrap and all overflow endings.
        push_req(KIND_INIT,  8'h00, 5'd0,  1'b0);
        push_req(KIND_CLEAR, 8'hFF, 5'd31, 1'b1);   // unused fields at their extremes
        push_req(KIND_SET,   8'h00, 5'd0,  1'b0);
        push_req(KIND_CHAR,  8'h00, 5'd0,  1'b0);   // zero byte is written like any other
        push_req(KIND_CHAR,  8'hFF, 5'd31, 1'b1);
        push_req(KIND_SET,   8'h00, 5'd15, 1'b0);
        push_req(KIND_CHAR,  8'hA5, 5'd0,  1'b1);   // fills line one, wraps to line two
        push_req(KIND_SET,   8'h00, 5'd16, 1'b0);
        push_req(KIND_SET,   8'h00, 5'd31, 1'b1);   // end marker on a non-char is ignored
        push_req(KIND_CHAR,  8'h5A, 5'd0,  1'b0);   // overflow mid string
        push_req(KIND_CHAR,  8'h41, 5'd0,  1'b0);   // dropped
        push_req(KIND_CHAR,  8'h42, 5'd0,  1'b1);   // dropped, ends the drop
        push_req(KIND_SET,   8'h00, 5'd31, 1'b0);
        push_req(KIND_CHAR,  8'h7E, 5'd0,  1'b1);   // overflow on the last char, no drop
        push_req(KIND_CHAR,  8'h43, 5'd0,  1'b0);
        push_req(KIND_SET,   8'h00, 5'd31, 1'b0);
        push_req(KIND_CHAR,  8'h44, 5'd0,  1'b0);   // overflow, drop starts
        push_req(KIND_CLEAR, 8'h00, 5'd0,  1'b1);   // another command ends the drop
        push_req(KIND_CHAR,  8'h80, 5'd0,  1'b0);
        push_req(KIND_INIT,  8'h3C, 5'd21, 1'b1);

        // Random part in three idling phases; each phase drains fully before the next,
        // which also keeps the sender paused until every predicted strobe has come back.
        for (int ph = 0; ph < 3; ph++) begin
            if (ph == 1) begin
                send_idle_pct  = 52;
                recv_stall_pct = 14;
            end else if (ph == 2) begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            goal = queued_cnt + PHASE_GOAL;
            while (queued_cnt < goal) begin
                // keep a short backlog so the stream never starves on its own
                while (cmd_backlog.size() >= 4)
                    @(negedge clk);
                pick = $urandom_range(0, 19);
                if (pick == 0) begin
                    push_req(KIND_INIT, 8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)),
                             1'($urandom_range(0, 1)));
                end else if (pick <= 2) begin
                    push_req(KIND_CLEAR, 8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)),
                             1'($urandom_range(0, 1)));
                end else if (pick <= 5) begin
                    push_req(KIND_SET, 8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)),
                             1'($urandom_range(0, 1)));
                end else begin
                    // a string, often started near the end of the display to force overflow
                    if (pick <= 11)
                        push_req(KIND_SET, 8'($urandom_range(0, 255)),
                                 5'($urandom_range(20, 31)), 1'($urandom_range(0, 1)));
                    len = $urandom_range(1, 16);
                    // the top pick leaves the end marker off: a broken string
                    for (int i = 0; i < len; i++)
                        push_req(KIND_CHAR, 8'($urandom_range(0, 255)),
                                 5'($urandom_range(0, 31)),
                                 (i == len - 1) && (pick != 19));
                end
            end
            while (accepted_cnt != queued_cnt || pending_strobes.size() != 0)
                @(negedge clk);
        end

        // let any stray strobe show up before the verdict
        repeat (20) @(negedge clk);
        $display("Run covered %0d requests (%0d producing strobes), %0d strobes, %0d overflows.",
                 accepted_cnt, productive_cnt, strobe_cnt, overflow_cnt);
        if (fail_cnt == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
